### hw/rtl/cyrillic_vigenere_cipher_macros.svh
// ---------------------------------------------------------------------------
// cyrillic_vigenere_cipher_macros.svh
// Assertion macros for the Cyrillic Vigenere cipher block.
// ---------------------------------------------------------------------------
`ifndef CYRILLIC_VIGENERE_CIPHER_MACROS_SVH
`define CYRILLIC_VIGENERE_CIPHER_MACROS_SVH

`ifndef SYNTH

// same-cycle implication
`define CVC_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cvc assertion failed");

// next-cycle implication
`define CVC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cvc assertion failed");

`else

`define CVC_ASSERT_IMPL(label, clk, rst, ante, cons)
`define CVC_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

### hw/rtl/cvc_pkg.sv
// ---------------------------------------------------------------------------
// cvc_pkg
// Shared types and constants of the Cyrillic Vigenere cipher block.
// ---------------------------------------------------------------------------
`default_nettype none

package cvc_pkg;

   localparam int CODE_W    = 16;
   localparam int LETTER_W  = 5;
   localparam int POS_W     = 4;
   localparam int LEN_W     = 5;
   localparam int KEY_SLOTS = 16;
   localparam int HALF_W    = 40;

   localparam logic [CODE_W-1:0] UPPER_BASE = 16'h0410;
   localparam logic [CODE_W-1:0] UPPER_LAST = 16'h042F;
   localparam logic [CODE_W-1:0] LOWER_BASE = 16'h0430;
   localparam logic [CODE_W-1:0] LOWER_LAST = 16'h044F;

   localparam logic MODE_ENCRYPT = 1'b0;

   typedef enum logic [1:0] {
      CSR_KEY_LOW  = 2'd0,
      CSR_KEY_HIGH = 2'd1,
      CSR_KEY_LEN  = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [KEY_SLOTS-1:0][LETTER_W-1:0] letters;
      logic [LEN_W-1:0]                   eff_len;
   } key_cfg_type;

   typedef struct packed {
      logic [CODE_W-1:0] code_out;
      logic              letter;
      logic [POS_W-1:0]  pos_next;
   } xform_res_type;

endpackage

`default_nettype wire

### hw/rtl/cvc_csr.sv
// ---------------------------------------------------------------------------
// cvc_csr
// Key registers and effective key length.
// ---------------------------------------------------------------------------
`default_nettype none

module cvc_csr #(
   parameter int KEY_LETTERS_MAX = 16
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        csr_wr_en,
   input  wire logic [1:0]                  csr_index,
   input  wire logic [cvc_pkg::HALF_W-1:0]  csr_wdata,
   output cvc_pkg::key_cfg_type             cfg
);

   localparam int CapInt = (KEY_LETTERS_MAX > cvc_pkg::KEY_SLOTS) ? cvc_pkg::KEY_SLOTS :
                           ((KEY_LETTERS_MAX < 1) ? 1 : KEY_LETTERS_MAX);
   localparam logic [cvc_pkg::LEN_W-1:0] CapLen = cvc_pkg::LEN_W'(CapInt);

   logic [cvc_pkg::HALF_W-1:0] key_low_ff;
   logic [cvc_pkg::HALF_W-1:0] key_high_ff;
   logic [cvc_pkg::LEN_W-1:0]  key_len_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff  <= '0;
         key_high_ff <= '0;
         key_len_ff  <= cvc_pkg::LEN_W'(1);
      end else if (csr_wr_en) begin
         unique case (cvc_pkg::csr_index_type'(csr_index))
            cvc_pkg::CSR_KEY_LOW:  key_low_ff  <= csr_wdata;
            cvc_pkg::CSR_KEY_HIGH: key_high_ff <= csr_wdata;
            cvc_pkg::CSR_KEY_LEN:  key_len_ff  <= csr_wdata[cvc_pkg::LEN_W-1:0];
            default: ;
         endcase
      end
   end

   // zero length acts as one, long length saturates at the cap
   always_comb begin
      cfg.letters = {key_high_ff, key_low_ff};
      priority if (key_len_ff == '0) begin
         cfg.eff_len = cvc_pkg::LEN_W'(1);
      end else if (key_len_ff > CapLen) begin
         cfg.eff_len = CapLen;
      end else begin
         cfg.eff_len = key_len_ff;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/cvc_xform.sv
// ---------------------------------------------------------------------------
// cvc_xform
// Letter detect, key shift and next key position for one word.
// ---------------------------------------------------------------------------
`default_nettype none

module cvc_xform (
   input  wire cvc_pkg::key_cfg_type         cfg,
   input  wire logic [cvc_pkg::POS_W-1:0]    pos_cur,
   input  wire logic                         mode,
   input  wire logic [cvc_pkg::CODE_W-1:0]   char_code,
   input  wire logic                         start_req,
   output cvc_pkg::xform_res_type            res
);

   logic [cvc_pkg::POS_W-1:0]    pos_sel;
   logic [cvc_pkg::POS_W-1:0]    pos_use;
   logic [cvc_pkg::LEN_W-1:0]    pos_inc;
   logic [cvc_pkg::LETTER_W-1:0] key_k;
   logic [cvc_pkg::LETTER_W-1:0] idx;
   logic [cvc_pkg::LETTER_W-1:0] rot;
   logic                         is_upper;
   logic                         is_lower;
   logic [cvc_pkg::CODE_W-1:0]   base;

   always_comb begin
      pos_sel = start_req ? '0 : pos_cur;
      // stale position after the length was lowered
      pos_use = ({1'b0, pos_sel} >= cfg.eff_len) ? '0 : pos_sel;
      key_k   = cfg.letters[pos_use];

      is_upper = (char_code >= cvc_pkg::UPPER_BASE) && (char_code <= cvc_pkg::UPPER_LAST);
      is_lower = (char_code >= cvc_pkg::LOWER_BASE) && (char_code <= cvc_pkg::LOWER_LAST);
      base     = is_upper ? cvc_pkg::UPPER_BASE : cvc_pkg::LOWER_BASE;

      // both bases end in 5'h10, so the index is the low bits plus 16
      idx = {~char_code[4], char_code[3:0]};
      rot = (mode == cvc_pkg::MODE_ENCRYPT) ? (idx + key_k) : (idx - key_k);

      pos_inc = {1'b0, pos_use} + cvc_pkg::LEN_W'(1);

      res.letter = is_upper || is_lower;
      if (res.letter) begin
         res.code_out = base + {{(cvc_pkg::CODE_W-cvc_pkg::LETTER_W){1'b0}}, rot};
         res.pos_next = (pos_inc >= cfg.eff_len) ? '0 : pos_inc[cvc_pkg::POS_W-1:0];
      end else begin
         res.code_out = char_code;
         res.pos_next = pos_sel;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/cyrillic_vigenere_cipher.sv
// ---------------------------------------------------------------------------
// cyrillic_vigenere_cipher
// Vigenere cipher over the 32-letter Russian alphabet, one word per cycle unless stalled.
// ---------------------------------------------------------------------------
// Takes one character word per cycle unless rsp_ready stalls, and returns
// one result word for each, in order. Key shift logic sits between an
// input register and a result register; the key position register is
// updated as a word moves from the input register to the result register,
// so back-to-back letters chain through it. The result register frees the
// input side while a finished word waits for rsp_ready. The user must write
// key registers through the csr_ port only while no word is in flight
// (the block does not enforce it); key length clamps to 1..KEY_LETTERS_MAX.
`default_nettype none

`include "cyrillic_vigenere_cipher_macros.svh"

module cyrillic_vigenere_cipher #(
   parameter int KEY_LETTERS_MAX = 16
) (
   input  wire logic                        clock,
   input  wire logic                        reset,

   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic                        req_mode,
   input  wire logic [cvc_pkg::CODE_W-1:0]  req_char_code,
   input  wire logic                        req_start_req,

   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic [cvc_pkg::CODE_W-1:0]       rsp_char_code_out,
   output logic                             rsp_was_letter,

   input  wire logic                        csr_wr_en,
   input  wire logic [1:0]                  csr_index,
   input  wire logic [cvc_pkg::HALF_W-1:0]  csr_wdata
);

   cvc_pkg::key_cfg_type   cfg;
   cvc_pkg::xform_res_type xf;

   logic                        s1_valid_ff;
   logic                        s1_mode_ff;
   logic [cvc_pkg::CODE_W-1:0]  s1_code_ff;
   logic                        s1_start_ff;
   logic [cvc_pkg::POS_W-1:0]   pos_ff;
   logic                        out_valid_ff;
   logic [cvc_pkg::CODE_W-1:0]  out_code_ff;
   logic                        out_letter_ff;
   logic                        s1_adv;
   logic                        req_fire;

   cvc_csr #(
      .KEY_LETTERS_MAX (KEY_LETTERS_MAX)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   cvc_xform u_xform (
      .cfg       (cfg),
      .pos_cur   (pos_ff),
      .mode      (s1_mode_ff),
      .char_code (s1_code_ff),
      .start_req (s1_start_ff),
      .res       (xf)
   );

   assign s1_adv    = s1_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_adv;
   assign req_fire  = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         pos_ff       <= '0;
      end else begin
         if (req_ready) begin
            s1_valid_ff <= req_valid;
         end
         if (s1_adv) begin
            out_valid_ff <= 1'b1;
            pos_ff       <= xf.pos_next;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_mode_ff  <= req_mode;
         s1_code_ff  <= req_char_code;
         s1_start_ff <= req_start_req;
      end
      if (s1_adv) begin
         out_code_ff   <= xf.code_out;
         out_letter_ff <= xf.letter;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_char_code_out = out_code_ff;
   assign rsp_was_letter    = out_letter_ff;

   `CVC_ASSERT_NEXT(a_adv_fills_out, clock, reset, s1_adv, out_valid_ff)
   `CVC_ASSERT_NEXT(a_pos_hold, clock, reset, !s1_adv, $stable(pos_ff))
   `CVC_ASSERT_NEXT(a_nonletter_keeps_pos, clock, reset, s1_adv && !xf.letter && !s1_start_ff, $stable(pos_ff))
   `CVC_ASSERT_IMPL(a_letter_in_range, clock, reset, out_valid_ff && out_letter_ff, (out_code_ff >= cvc_pkg::UPPER_BASE) && (out_code_ff <= cvc_pkg::LOWER_LAST))

endmodule

`default_nettype wire

### verif/cyrillic_vigenere_cipher_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// cyrillic_vigenere_cipher_checker
// Passive scoreboard for the Cyrillic Vigenere cipher block.
// ---------------------------------------------------------------------------
// Tracks key register writes on the csr_ port and runs its own cipher
// model on every word accepted on req_. The predicted words are queued in
// order and compared field by field with each word accepted on rsp_.
module cyrillic_vigenere_cipher_checker #(
   parameter int KEY_LETTERS_MAX = cvc_pkg::KEY_SLOTS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_ready,
   input  logic                        req_mode,
   input  logic [cvc_pkg::CODE_W-1:0]  req_char_code,
   input  logic                        req_start_req,
   input  logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  logic [cvc_pkg::CODE_W-1:0]  rsp_char_code_out,
   input  logic                        rsp_was_letter,
   input  logic                        csr_wr_en,
   input  logic [1:0]                  csr_index,
   input  logic [cvc_pkg::HALF_W-1:0]  csr_wdata,
   output int                          cipher_fails,
   output int                          words_in_flight,
   output int                          words_checked,
   output int                          letters_checked
);

   typedef struct packed {
      logic [cvc_pkg::CODE_W-1:0] code;
      logic                       letter;
   } cipher_word_type;

   cipher_word_type            expected_words[$];
   logic [cvc_pkg::HALF_W-1:0] key_low;
   logic [cvc_pkg::HALF_W-1:0] key_high;
   logic [cvc_pkg::LEN_W-1:0]  key_len;
   logic [cvc_pkg::POS_W-1:0]  key_pos;

   initial begin
      cipher_fails    = 0;
      words_in_flight = 0;
      words_checked   = 0;
      letters_checked = 0;
   end

   // length register clamped to 1..KEY_LETTERS_MAX and to at most KEY_SLOTS
   function automatic logic [cvc_pkg::LEN_W-1:0] active_length();
      int unsigned n;
      n = key_len;
      if (n < 1) n = 1;
      if (n > KEY_LETTERS_MAX) n = KEY_LETTERS_MAX;
      if (n > cvc_pkg::KEY_SLOTS) n = cvc_pkg::KEY_SLOTS;
      return cvc_pkg::LEN_W'(n);
   endfunction

   function automatic logic [cvc_pkg::LETTER_W-1:0] key_letter_at(
      logic [cvc_pkg::POS_W-1:0] p);
      logic [cvc_pkg::HALF_W-1:0] half;
      half = p[cvc_pkg::POS_W-1] ? key_high : key_low;
      return half[p[2:0]*cvc_pkg::LETTER_W +: cvc_pkg::LETTER_W];
   endfunction

   // one cipher step; a restart clears key_pos, which advances on letters only
   function automatic cipher_word_type cipher_step(logic m, logic [cvc_pkg::CODE_W-1:0] c,
                                                   logic s);
      logic [cvc_pkg::LEN_W-1:0]    len;
      logic [cvc_pkg::POS_W:0]      pos;
      logic [cvc_pkg::CODE_W-1:0]   base;
      logic [cvc_pkg::LETTER_W-1:0] idx;
      logic [cvc_pkg::LETTER_W-1:0] shift;
      cipher_word_type              w;
      len = active_length();
      if (s) key_pos = '0;
      pos = {1'b0, key_pos};
      // position left over from a longer key restarts at letter 0
      if (pos >= len) pos = '0;
      base = '0;
      w.code = c;
      w.letter = 1'b0;
      if (c >= cvc_pkg::UPPER_BASE && c <= cvc_pkg::UPPER_LAST) begin
         base = cvc_pkg::UPPER_BASE;
         w.letter = 1'b1;
      end else if (c >= cvc_pkg::LOWER_BASE && c <= cvc_pkg::LOWER_LAST) begin
         base = cvc_pkg::LOWER_BASE;
         w.letter = 1'b1;
      end
      if (w.letter) begin
         idx = cvc_pkg::LETTER_W'(c - base);
         shift = key_letter_at(pos[cvc_pkg::POS_W-1:0]);
         // five-bit arithmetic gives the mod-32 wrap
         idx = (m == cvc_pkg::MODE_ENCRYPT) ? idx + shift : idx - shift;
         w.code = base + cvc_pkg::CODE_W'(idx);
         pos = pos + 1'b1;
         if (pos >= len) pos = '0;
         key_pos = pos[cvc_pkg::POS_W-1:0];
      end
      return w;
   endfunction

   always @(posedge clock) begin
      cipher_word_type got;
      cipher_word_type want;
      if (reset) begin
         key_low  = '0;
         key_high = '0;
         key_len  = cvc_pkg::LEN_W'(1);
         key_pos  = '0;
         expected_words.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               cvc_pkg::CSR_KEY_LOW:  key_low  = csr_wdata;
               cvc_pkg::CSR_KEY_HIGH: key_high = csr_wdata;
               cvc_pkg::CSR_KEY_LEN:  key_len  = csr_wdata[cvc_pkg::LEN_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            expected_words.push_back(cipher_step(req_mode, req_char_code, req_start_req));
         if ($isunknown(rsp_valid)) begin
            cipher_fails++;
            $error("rsp_valid is unknown");
         end else if (rsp_valid && rsp_ready) begin
            got.code = rsp_char_code_out;
            got.letter = rsp_was_letter;
            if (expected_words.size() == 0) begin
               cipher_fails++;
               $error("unexpected result word: char_code_out %h", got.code);
            end else begin
               want = expected_words.pop_front();
               words_checked++;
               if (want.letter) letters_checked++;
               if (got.code !== want.code) begin
                  cipher_fails++;
                  $error("char_code_out: expected %h, actual %h", want.code, got.code);
               end
               if (got.letter !== want.letter) begin
                  cipher_fails++;
                  $error("was_letter: expected %b, actual %b", want.letter, got.letter);
               end
            end
         end
      end
      words_in_flight = expected_words.size();
   end

endmodule

### verif/tb_cyrillic_vigenere_cipher.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_cyrillic_vigenere_cipher
// Stimulus and verdict for the Cyrillic Vigenere cipher block.
// ---------------------------------------------------------------------------
// A directed pass walks the alphabet edges, both modes, message restarts,
// key length clamping and a stale key position. Random messages of mixed
// letters and other codes follow under eight key settings and four
// sender/receiver idle mixes, including a long receiver hold-off.
module tb_cyrillic_vigenere_cipher;

   localparam logic [1:0] CSR_SPARE = 2'd3;   // unmapped register slot

   logic                         clock;
   logic                         reset;
   logic                         req_valid;
   logic                         req_ready;
   logic                         req_mode;
   logic [cvc_pkg::CODE_W-1:0]   req_char_code;
   logic                         req_start_req;
   logic                         rsp_valid;
   logic                         rsp_ready;
   logic [cvc_pkg::CODE_W-1:0]   rsp_char_code_out;
   logic                         rsp_was_letter;
   logic                         csr_wr_en;
   logic [1:0]                   csr_index;
   logic [cvc_pkg::HALF_W-1:0]   csr_wdata;

   int cipher_fails;
   int words_in_flight;
   int words_checked;
   int letters_checked;
   int words_sent;
   int sender_idle_pct;
   int receiver_stall_pct;
   bit rsp_hold_want;

   int sender_idle_mix[4]   = '{0, 59, 0, 19};
   int receiver_stall_mix[4] = '{0, 0, 59, 19};

   cyrillic_vigenere_cipher #(
      .KEY_LETTERS_MAX(cvc_pkg::KEY_SLOTS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_mode(req_mode),
      .req_char_code(req_char_code),
      .req_start_req(req_start_req),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_char_code_out(rsp_char_code_out),
      .rsp_was_letter(rsp_was_letter),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   cyrillic_vigenere_cipher_checker #(
      .KEY_LETTERS_MAX(cvc_pkg::KEY_SLOTS)
   ) u_checker (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_mode(req_mode),
      .req_char_code(req_char_code),
      .req_start_req(req_start_req),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_char_code_out(rsp_char_code_out),
      .rsp_was_letter(rsp_was_letter),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .cipher_fails(cipher_fails),
      .words_in_flight(words_in_flight),
      .words_checked(words_checked),
      .letters_checked(letters_checked)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   initial begin
      #5_000_000;
      $display("tb_cyrillic_vigenere_cipher: FAIL");
      $finish;
   end

   // receiver: random stalls, plus a hold-off on request
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_want) begin
            rsp_hold_want = 1'b0;
            hold_left = 80;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready = 1'b0;
         end else begin
            rsp_ready = ($urandom_range(99) >= receiver_stall_pct);
         end
      end
   end

   task automatic send_word(input logic m, input logic [cvc_pkg::CODE_W-1:0] c,
                            input logic s);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid = 1'b0;
         req_mode = 1'($urandom);
         req_char_code = cvc_pkg::CODE_W'($urandom);
         req_start_req = 1'($urandom);
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_mode = m;
      req_char_code = c;
      req_start_req = s;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      words_sent++;
   endtask

   task automatic wait_drained();
      req_valid = 1'b0;
      while (words_in_flight != 0) @(negedge clock);
      repeat (4) @(negedge clock);   // two-stage pipe plus margin
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [cvc_pkg::HALF_W-1:0] data);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   // length write carries junk above the 5-bit field
   task automatic load_key(input logic [cvc_pkg::HALF_W-1:0] lo,
                           input logic [cvc_pkg::HALF_W-1:0] hi,
                           input logic [cvc_pkg::LEN_W-1:0] len);
      logic [cvc_pkg::HALF_W-1:0] len_word;
      len_word = cvc_pkg::HALF_W'({$urandom, $urandom});
      len_word[cvc_pkg::LEN_W-1:0] = len;
      write_csr(cvc_pkg::CSR_KEY_LOW, lo);
      write_csr(cvc_pkg::CSR_KEY_HIGH, hi);
      write_csr(cvc_pkg::CSR_KEY_LEN, len_word);
   endtask

   // one message: restart on the first word, mostly letters, some noise
   task automatic send_random_message(input int n_words);
      logic                       m;
      logic [cvc_pkg::CODE_W-1:0] c;
      int                         pick;
      m = 1'($urandom);
      for (int i = 0; i < n_words; i++) begin
         pick = $urandom_range(99);
         if (pick < 60) begin
            c = cvc_pkg::CODE_W'(($urandom_range(1) ? cvc_pkg::UPPER_BASE : cvc_pkg::LOWER_BASE)
                                 + $urandom_range(31));
         end else if (pick < 70) begin
            case ($urandom_range(3))
               0: c = cvc_pkg::UPPER_BASE - 1'b1;
               1: c = cvc_pkg::LOWER_LAST + 1'b1;
               2: c = $urandom_range(1) ? cvc_pkg::UPPER_LAST : cvc_pkg::LOWER_BASE;
               default: c = cvc_pkg::CODE_W'((cvc_pkg::UPPER_BASE
                                               ^ (cvc_pkg::CODE_W'(1) << $urandom_range(15)))
                                              + $urandom_range(31));
            endcase
         end else if (pick < 85) begin
            c = cvc_pkg::CODE_W'(16'h0400 + $urandom_range(255));
         end else begin
            c = cvc_pkg::CODE_W'($urandom);
         end
         send_word(($urandom_range(19) == 0) ? ~m : m, c,
                   (i == 0) || ($urandom_range(29) == 0));
      end
   endtask

   initial begin
      int                         sent;
      int                         n;
      logic [cvc_pkg::HALF_W-1:0] lo;
      logic [cvc_pkg::HALF_W-1:0] hi;
      logic [cvc_pkg::LEN_W-1:0]  len;

      reset = 1'b1;
      req_valid = 1'b0;
      req_mode = 1'b0;
      req_char_code = '0;
      req_start_req = 1'b0;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      words_sent = 0;
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset key: all-zero letters, length 1
      send_word(cvc_pkg::MODE_ENCRYPT, cvc_pkg::UPPER_BASE, 1'b1);
      wait_drained();

      // letters 0..2 = 1, 31, 16; upper half all ones
      load_key({25'h0, 5'd16, 5'd31, 5'd1}, {cvc_pkg::HALF_W{1'b1}}, cvc_pkg::LEN_W'(3));
      send_word(cvc_pkg::MODE_ENCRYPT, cvc_pkg::UPPER_BASE, 1'b1);
      send_word(cvc_pkg::MODE_ENCRYPT, cvc_pkg::UPPER_LAST, 1'b0);
      send_word(cvc_pkg::MODE_ENCRYPT, cvc_pkg::LOWER_BASE, 1'b0);
      // wraps to first lower letter
      send_word(cvc_pkg::MODE_ENCRYPT, cvc_pkg::LOWER_LAST, 1'b0);
      send_word(cvc_pkg::MODE_ENCRYPT, cvc_pkg::UPPER_BASE - 1'b1, 1'b0);
      send_word(cvc_pkg::MODE_ENCRYPT, cvc_pkg::LOWER_LAST + 1'b1, 1'b0);
      send_word(cvc_pkg::MODE_ENCRYPT, 16'h0401, 1'b0);       // YO is not in the alphabet
      send_word(cvc_pkg::MODE_ENCRYPT, 16'h0000, 1'b0);
      send_word(cvc_pkg::MODE_ENCRYPT, 16'hFFFF, 1'b0);
      send_word(~cvc_pkg::MODE_ENCRYPT, cvc_pkg::UPPER_BASE, 1'b1);
      send_word(~cvc_pkg::MODE_ENCRYPT, cvc_pkg::LOWER_LAST, 1'b0);
      send_word(~cvc_pkg::MODE_ENCRYPT, 16'h0420, 1'b1);
      wait_drained();

      // stale position: walk a long key, then shorten it
      write_csr(cvc_pkg::CSR_KEY_LEN, cvc_pkg::HALF_W'(16));
      for (int i = 0; i < 6; i++)
         send_word(cvc_pkg::MODE_ENCRYPT, cvc_pkg::LOWER_BASE + cvc_pkg::CODE_W'(i), i == 0);
      wait_drained();
      write_csr(cvc_pkg::CSR_KEY_LEN, cvc_pkg::HALF_W'(3));
      send_word(cvc_pkg::MODE_ENCRYPT, 16'h0435, 1'b0);
      wait_drained();

      // zero length acts as one, oversize saturates, unmapped slot ignored
      write_csr(cvc_pkg::CSR_KEY_LEN, cvc_pkg::HALF_W'(0));
      send_word(cvc_pkg::MODE_ENCRYPT, 16'h043A, 1'b0);
      wait_drained();
      write_csr(cvc_pkg::CSR_KEY_LEN, cvc_pkg::HALF_W'(31));
      write_csr(CSR_SPARE, cvc_pkg::HALF_W'({$urandom, $urandom}));
      send_word(~cvc_pkg::MODE_ENCRYPT, 16'h0417, 1'b0);
      wait_drained();

      for (int seg = 0; seg < 8; seg++) begin
         wait_drained();
         sender_idle_pct = sender_idle_mix[seg % 4];
         receiver_stall_pct = receiver_stall_mix[seg % 4];
         lo = cvc_pkg::HALF_W'({$urandom, $urandom});
         hi = cvc_pkg::HALF_W'({$urandom, $urandom});
         case (seg)
            0: len = cvc_pkg::LEN_W'(16);
            1: begin
               len = cvc_pkg::LEN_W'(1);
               lo = {cvc_pkg::HALF_W{1'b1}};
               hi = {cvc_pkg::HALF_W{1'b1}};
            end
            2: begin
               len = cvc_pkg::LEN_W'(0);
               lo = '0;
               hi = '0;
            end
            3: len = cvc_pkg::LEN_W'(31);
            4: len = cvc_pkg::LEN_W'(17);
            default: len = cvc_pkg::LEN_W'($urandom_range(31));
         endcase
         load_key(lo, hi, len);
         if (seg == 4) begin
            // hold the receiver off while the sender keeps pushing
            rsp_hold_want = 1'b1;
            send_random_message(40);
         end
         sent = 0;
         while (sent < 100) begin
            if (seg == 6 && sent >= 50 && sent < 60) begin
               wait_drained();
               sent = 60;
            end
            n = $urandom_range(24, 1);
            send_random_message(n);
            sent += n;
         end
      end

      wait_drained();
      repeat (10) @(negedge clock);
      $display("Sent %0d words; %0d results checked, %0d of them letters.",
               words_sent, words_checked, letters_checked);
      $display("Covered alphabet edges, both modes, clamped key lengths and four idle mixes.");
      if (cipher_fails == 0) begin
         $display("tb_cyrillic_vigenere_cipher: PASS");
      end else begin
         $display("tb_cyrillic_vigenere_cipher: FAIL");
      end
      $finish;
   end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/cvc_pkg.sv
hw/rtl/cvc_csr.sv
hw/rtl/cvc_xform.sv
hw/rtl/cyrillic_vigenere_cipher.sv
verif/cyrillic_vigenere_cipher_checker.sv
verif/tb_cyrillic_vigenere_cipher.sv
